### rtl/core/rx16_pkg.sv
// Shared types, opcodes and constants of the RISC16 execute stage.
package rx16_pkg;

	localparam int MEM_WORDS_DEF = 4096;
	localparam int WORD_BITS_DEF = 16;
	localparam int RF_DEPTH      = 17;
	localparam int RF_AW         = 5;
	localparam logic [RF_AW-1:0] LINK_REG = 5'd16;

	typedef enum logic [3:0] {
		OP_ADD   = 4'd0,
		OP_SUB   = 4'd1,
		OP_ADDI  = 4'd2,
		OP_SHIFT = 4'd3,
		OP_AND   = 4'd4,
		OP_OR    = 4'd5,
		OP_XOR   = 4'd6,
		OP_NOT   = 4'd7,
		OP_SLT   = 4'd8,
		OP_LW    = 4'd9,
		OP_SW    = 4'd10,
		OP_LUI   = 4'd11,
		OP_BEQ   = 4'd12,
		OP_BLT   = 4'd13,
		OP_J     = 4'd14,
		OP_JAL   = 4'd15
	} op_t;

	typedef struct packed {
		logic [3:0]        op;
		logic [3:0]        src_a;
		logic [3:0]        src_b;
		logic [3:0]        dest;
		logic signed [3:0] imm4;
		logic signed [7:0] imm8;
		logic [15:0]       pc_in;
	} in_item_t;

	typedef struct packed {
		logic [15:0]        next_pc;
		logic               reg_written;
		logic [4:0]         written_index;
		logic signed [15:0] written_value;
	} out_item_t;

	typedef struct packed {
		logic             wr;
		logic [RF_AW-1:0] widx;
		logic [15:0]      npc;
		logic             is_lw;
		logic             is_sw;
	} alu_ctl_t;

	typedef struct packed {
		logic             en;
		logic [RF_AW-1:0] idx;
	} rf_wr_t;

	typedef struct packed {
		logic rd;
		logic wr;
	} dmem_ctl_t;

endpackage

### rtl/core/rx16_regfile.sv
// Register file: two mirrored synchronous banks, three read ports, valid bits for reset.
module rx16_regfile #(
	parameter int WORD_BITS = rx16_pkg::WORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rd_en,
	input  logic [3:0]           rd_idx_a,
	input  logic [3:0]           rd_idx_b,
	input  logic [3:0]           rd_idx_d,
	input  rx16_pkg::rf_wr_t     wr,
	input  logic [WORD_BITS-1:0] wr_data,
	output logic [WORD_BITS-1:0] rd_a,
	output logic [WORD_BITS-1:0] rd_b,
	output logic [WORD_BITS-1:0] rd_d
);
	import rx16_pkg::*;

	logic [WORD_BITS-1:0] bank0_q [RF_DEPTH];
	logic [WORD_BITS-1:0] bank1_q [RF_DEPTH];
	logic [RF_DEPTH-1:0]  vld_q;
	logic [WORD_BITS-1:0] da_q, db_q, dd_q;
	logic                 va_q, vb_q, vd_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			bank0_q[wr.idx] <= wr_data;
			bank1_q[wr.idx] <= wr_data;
		end
		if (rd_en) begin
			da_q <= bank0_q[RF_AW'(rd_idx_a)];
			db_q <= bank0_q[RF_AW'(rd_idx_b)];
			dd_q <= bank1_q[RF_AW'(rd_idx_d)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			va_q  <= 1'b0;
			vb_q  <= 1'b0;
			vd_q  <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.idx] <= 1'b1;
			end
			if (rd_en) begin
				va_q <= vld_q[RF_AW'(rd_idx_a)];
				vb_q <= vld_q[RF_AW'(rd_idx_b)];
				vd_q <= vld_q[RF_AW'(rd_idx_d)];
			end
		end
	end

	assign rd_a = va_q ? da_q : '0;
	assign rd_b = vb_q ? db_q : '0;
	assign rd_d = vd_q ? dd_q : '0;

endmodule

### rtl/core/rx16_dmem.sv
// Data memory: single-port synchronous RAM with a clearing sweep after reset.
module rx16_dmem #(
	parameter int MEM_WORDS = rx16_pkg::MEM_WORDS_DEF,
	parameter int WORD_BITS = rx16_pkg::WORD_BITS_DEF,
	localparam int AW = $clog2(MEM_WORDS)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rx16_pkg::dmem_ctl_t   ctl,
	input  logic [AW-1:0]         addr,
	input  logic [WORD_BITS-1:0]  wdata,
	output logic [WORD_BITS-1:0]  rdata,
	output logic                  busy
);
	import rx16_pkg::*;

	logic [WORD_BITS-1:0] mem_q [MEM_WORDS];
	logic [WORD_BITS-1:0] rdata_q;
	logic [AW-1:0]        clr_q;
	logic                 clearing_q;

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem_q[clr_q] <= '0;
		end else if (ctl.wr) begin
			mem_q[addr] <= wdata;
		end
		if (ctl.rd) begin
			rdata_q <= mem_q[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			clr_q <= clr_q + AW'(1);
			if (clr_q == AW'(MEM_WORDS - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	assign rdata = rdata_q;
	assign busy  = clearing_q;

endmodule

### rtl/core/rx16_alu.sv
// Execute logic: result value, write target, next pc and memory address of one instruction.
module rx16_alu #(
	parameter int MEM_WORDS = rx16_pkg::MEM_WORDS_DEF,
	parameter int WORD_BITS = rx16_pkg::WORD_BITS_DEF,
	localparam int AW = $clog2(MEM_WORDS)
) (
	input  rx16_pkg::in_item_t   ins,
	input  logic [WORD_BITS-1:0] a,
	input  logic [WORD_BITS-1:0] b,
	output rx16_pkg::alu_ctl_t   ctl,
	output logic [WORD_BITS-1:0] value,
	output logic [AW-1:0]        addr
);
	import rx16_pkg::*;

	logic [WORD_BITS-1:0] sum, imm8_w, shl, shr, shr_raw;
	logic [7:0]           sh_n;
	logic                 lt;
	logic                 wr_raw;
	logic [RF_AW-1:0]     widx_raw;
	logic [15:0]          br_tgt, j_tgt, npc;
	logic                 is_lw, is_sw;

	always_comb begin
		sum     = a + b;
		imm8_w  = WORD_BITS'(ins.imm8);
		sh_n    = ins.imm8[7] ? (~ins.imm8 + 8'd1) : ins.imm8;
		shl     = (sh_n >= 8'(WORD_BITS)) ? '0 : (a << sh_n);
		shr_raw = $signed(a) >>> sh_n;
		shr     = (sh_n >= 8'(WORD_BITS)) ? {WORD_BITS{a[WORD_BITS-1]}} : shr_raw;
		lt      = $signed(a) < $signed(b);
		br_tgt  = ins.pc_in + 16'(ins.imm4);
		j_tgt   = a[15:0] + 16'(ins.imm8);

		wr_raw   = 1'b0;
		widx_raw = RF_AW'(ins.dest);
		value    = '0;
		npc      = ins.pc_in;
		is_lw    = 1'b0;
		is_sw    = 1'b0;

		unique case (op_t'(ins.op))
			OP_ADD: begin
				wr_raw = 1'b1;
				value  = sum;
			end
			OP_SUB: begin
				wr_raw = 1'b1;
				value  = a - b;
			end
			OP_ADDI: begin
				wr_raw   = 1'b1;
				widx_raw = RF_AW'(ins.src_a);
				value    = a + imm8_w;
			end
			OP_SHIFT: begin
				wr_raw   = 1'b1;
				widx_raw = RF_AW'(ins.src_a);
				value    = ins.imm8[7] ? shl : shr;
			end
			OP_AND: begin
				wr_raw = 1'b1;
				value  = a & b;
			end
			OP_OR: begin
				wr_raw = 1'b1;
				value  = a | b;
			end
			OP_XOR: begin
				wr_raw = 1'b1;
				value  = a ^ b;
			end
			OP_NOT: begin
				wr_raw   = 1'b1;
				widx_raw = RF_AW'(ins.src_a);
				value    = ~a;
			end
			OP_SLT: begin
				wr_raw = 1'b1;
				value  = WORD_BITS'(lt);
			end
			OP_LW: begin
				wr_raw = 1'b1;
				is_lw  = 1'b1;
			end
			OP_SW: begin
				is_sw = 1'b1;
			end
			OP_LUI: begin
				wr_raw   = 1'b1;
				widx_raw = RF_AW'(ins.src_a);
				value    = imm8_w << 8;
			end
			OP_BEQ: begin
				if (a == b) begin
					npc = br_tgt;
				end
			end
			OP_BLT: begin
				if (lt) begin
					npc = br_tgt;
				end
			end
			OP_J: begin
				npc = j_tgt;
			end
			OP_JAL: begin
				wr_raw   = 1'b1;
				widx_raw = LINK_REG;
				value    = WORD_BITS'(ins.pc_in);
				npc      = j_tgt;
			end
		endcase

		ctl.wr    = wr_raw && (widx_raw != '0);
		ctl.widx  = ctl.wr ? widx_raw : '0;
		ctl.npc   = npc;
		ctl.is_lw = is_lw;
		ctl.is_sw = is_sw;
	end

	// address = (a + b) mod MEM_WORDS
	if ((MEM_WORDS & (MEM_WORDS - 1)) == 0) begin : g_addr_mask
		assign addr = sum[AW-1:0];
	end else begin : g_addr_mod
		// quotient by reciprocal multiply, exact for every WORD_BITS-bit sum
		localparam int SH = WORD_BITS + AW;
		localparam logic [WORD_BITS:0] RECIP = (WORD_BITS+1)'(
			((64'd1 << SH) + 64'(MEM_WORDS) - 64'd1) / 64'(MEM_WORDS));

		logic [2*WORD_BITS:0]  prod;
		logic [WORD_BITS-1:0]  quo, rem;

		always_comb begin
			prod = (2*WORD_BITS+1)'(sum) * (2*WORD_BITS+1)'(RECIP);
			quo  = WORD_BITS'(prod >> SH);
			rem  = sum - quo * WORD_BITS'(MEM_WORDS);
		end

		assign addr = rem[AW-1:0];
	end

endmodule

### rtl/core/risc16_execute_stage.sv
// Top level of the RISC16 execute stage: pipeline, forwarding and handshakes.
// Takes one instruction item per cycle while in_ready is high and returns its result item
// from stage 2; with out_ready held high it sustains one item per clock with no bubbles,
// since results still in flight and the last register write are forwarded to the
// operands. Stage 1 reads the register file (synchronous read), executes and
// issues the data memory access; stage 2 holds the result, the lw read data arrives
// there, and the register write happens when the result item is taken. A stalled
// result stops both stages, but an item is still taken into an empty stage 1.
// After reset the data memory is cleared one word per cycle, over all MEM_WORDS words, with
// in_ready low. The address is a+b modulo MEM_WORDS: its low bits when MEM_WORDS is a
// power of two, otherwise a reciprocal multiply and subtract within stage 1.
module risc16_execute_stage #(
	parameter int MEM_WORDS = rx16_pkg::MEM_WORDS_DEF,
	parameter int WORD_BITS = rx16_pkg::WORD_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rx16_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output rx16_pkg::out_item_t out_data
);
	import rx16_pkg::*;

	localparam int AW = $clog2(MEM_WORDS);

	logic                 in_acc, s1_mv, out_acc, busy;
	in_item_t             ins_s1;
	logic                 v_s1, v_s2;
	alu_ctl_t             ctl_s1, ctl_s2;
	logic [WORD_BITS-1:0] val_s1, val_s2;
	logic [WORD_BITS-1:0] rf_a, rf_b, rf_d, op_a, op_b, op_d, fwd2_val, dm_rdata;
	logic [AW-1:0]        dm_addr;
	dmem_ctl_t            dm_ctl;
	rf_wr_t               rf_wr;
	logic                 wb_vld_q;
	logic [RF_AW-1:0]     wb_idx_q;
	logic [WORD_BITS-1:0] wb_val_q;

	function automatic logic [WORD_BITS-1:0] fwd(
		input logic [3:0]           idx,
		input logic [WORD_BITS-1:0] rf,
		input logic                 s2_en,
		input logic [RF_AW-1:0]     s2_idx,
		input logic [WORD_BITS-1:0] s2_val,
		input logic                 wb_en,
		input logic [RF_AW-1:0]     wb_idx,
		input logic [WORD_BITS-1:0] wb_val
	);
		logic [WORD_BITS-1:0] r;
		priority if (s2_en && s2_idx == RF_AW'(idx)) begin
			r = s2_val;
		end else if (wb_en && wb_idx == RF_AW'(idx)) begin
			r = wb_val;
		end else begin
			r = rf;
		end
		return r;
	endfunction

	assign out_acc  = v_s2 && out_ready;
	assign s1_mv    = v_s1 && (!v_s2 || out_ready);
	assign in_ready = !busy && (!v_s1 || s1_mv);
	assign in_acc   = in_valid && in_ready;

	assign fwd2_val = ctl_s2.is_lw ? dm_rdata : val_s2;

	always_comb begin
		op_a = fwd(ins_s1.src_a, rf_a, v_s2 && ctl_s2.wr, ctl_s2.widx, fwd2_val,
			wb_vld_q, wb_idx_q, wb_val_q);
		op_b = fwd(ins_s1.src_b, rf_b, v_s2 && ctl_s2.wr, ctl_s2.widx, fwd2_val,
			wb_vld_q, wb_idx_q, wb_val_q);
		op_d = fwd(ins_s1.dest, rf_d, v_s2 && ctl_s2.wr, ctl_s2.widx, fwd2_val,
			wb_vld_q, wb_idx_q, wb_val_q);
	end

	rx16_regfile #(
		.WORD_BITS(WORD_BITS)
	) u_regfile (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (in_acc),
		.rd_idx_a (in_data.src_a),
		.rd_idx_b (in_data.src_b),
		.rd_idx_d (in_data.dest),
		.wr       (rf_wr),
		.wr_data  (fwd2_val),
		.rd_a     (rf_a),
		.rd_b     (rf_b),
		.rd_d     (rf_d)
	);

	rx16_alu #(
		.MEM_WORDS(MEM_WORDS),
		.WORD_BITS(WORD_BITS)
	) u_alu (
		.ins   (ins_s1),
		.a     (op_a),
		.b     (op_b),
		.ctl   (ctl_s1),
		.value (val_s1),
		.addr  (dm_addr)
	);

	assign dm_ctl.rd = s1_mv && ctl_s1.is_lw;
	assign dm_ctl.wr = s1_mv && ctl_s1.is_sw;

	rx16_dmem #(
		.MEM_WORDS(MEM_WORDS),
		.WORD_BITS(WORD_BITS)
	) u_dmem (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (dm_ctl),
		.addr   (dm_addr),
		.wdata  (op_d),
		.rdata  (dm_rdata),
		.busy   (busy)
	);

	assign rf_wr.en  = out_acc && ctl_s2.wr;
	assign rf_wr.idx = ctl_s2.widx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			wb_vld_q <= 1'b0;
		end else begin
			if (in_acc) begin
				v_s1 <= 1'b1;
			end else if (s1_mv) begin
				v_s1 <= 1'b0;
			end
			if (s1_mv) begin
				v_s2 <= 1'b1;
			end else if (out_acc) begin
				v_s2 <= 1'b0;
			end
			if (rf_wr.en) begin
				wb_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			ins_s1 <= in_data;
		end
		if (s1_mv) begin
			ctl_s2 <= ctl_s1;
			val_s2 <= val_s1;
		end
		if (rf_wr.en) begin
			wb_idx_q <= ctl_s2.widx;
			wb_val_q <= fwd2_val;
		end
	end

	assign out_valid = v_s2;

	always_comb begin
		out_data.next_pc       = ctl_s2.npc;
		out_data.reg_written   = ctl_s2.wr;
		out_data.written_index = ctl_s2.widx;
		out_data.written_value = ctl_s2.wr ? fwd2_val[15:0] : '0;
	end

	a_no_r0_write: assert property (@(posedge clk) disable iff (!arst_n)
		rf_wr.en |-> rf_wr.idx != '0)
		else $error("register 0 written");

	a_no_mem_during_clear: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !(dm_ctl.rd || dm_ctl.wr || v_s1 || v_s2))
		else $error("data memory access during clearing sweep");

	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !out_ready |=> v_s2 && $stable(ctl_s2) && $stable(out_data))
		else $error("stalled result lost or changed");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !s1_mv |=> v_s1 && $stable(ins_s1) && !$past(in_acc))
		else $error("stage 1 overwritten while held");

endmodule

### test/testbench.sv
// Testbench for risc16_execute_stage: directed table plus random instructions against a predictor.
module testbench;
	import rx16_pkg::*;

	localparam int MEM_WORDS = 4096;

	typedef struct {
		in_item_t  instr;
		bit        known;
		out_item_t want;
	} dir_row_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_data;

	logic [15:0] rf_model [0:RF_DEPTH-1];
	logic [15:0] dmem_model [0:MEM_WORDS-1];
	out_item_t   pending_results [$];
	dir_row_t    dir_tab [$];
	int          mismatches = 0;
	int          gap_pct = 0;
	int          stall_pct = 0;

	risc16_execute_stage #(
		.MEM_WORDS(MEM_WORDS),
		.WORD_BITS(16)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#4000000;
		$display("testbench: done, errors");
		$finish;
	end

	// Executes one instruction on the model state and returns its result item.
	function automatic out_item_t execute_instr(in_item_t x);
		logic [15:0] a, b, sum, npc, wval, simm8, simm4;
		logic [4:0]  widx;
		logic        wr;
		int          k;
		out_item_t   r;
		rf_model[0] = '0;
		a = rf_model[x.src_a];
		b = rf_model[x.src_b];
		sum = a + b;
		simm8 = {{8{x.imm8[7]}}, x.imm8};
		simm4 = {{12{x.imm4[3]}}, x.imm4};
		npc = x.pc_in;
		wr = 1'b0;
		widx = '0;
		wval = '0;
		case (x.op)
			OP_ADD: begin wr = 1'b1; widx = 5'(x.dest); wval = a + b; end
			OP_SUB: begin wr = 1'b1; widx = 5'(x.dest); wval = a - b; end
			OP_ADDI: begin wr = 1'b1; widx = 5'(x.src_a); wval = a + simm8; end
			OP_SHIFT: begin
				wr = 1'b1;
				widx = 5'(x.src_a);
				k = int'($signed(x.imm8));
				if (k < 0) begin
					wval = (-k >= 16) ? 16'h0000 : a << (-k);
				end else begin
					wval = (k >= 16) ? {16{a[15]}} : 16'($signed(a) >>> k);
				end
			end
			OP_AND: begin wr = 1'b1; widx = 5'(x.dest); wval = a & b; end
			OP_OR: begin wr = 1'b1; widx = 5'(x.dest); wval = a | b; end
			OP_XOR: begin wr = 1'b1; widx = 5'(x.dest); wval = a ^ b; end
			OP_NOT: begin wr = 1'b1; widx = 5'(x.src_a); wval = ~a; end
			OP_SLT: begin
				wr = 1'b1;
				widx = 5'(x.dest);
				wval = ($signed(a) < $signed(b)) ? 16'd1 : 16'd0;
			end
			OP_LW: begin
				wr = 1'b1;
				widx = 5'(x.dest);
				wval = dmem_model[sum % MEM_WORDS];
			end
			OP_SW: dmem_model[sum % MEM_WORDS] = rf_model[x.dest];
			OP_LUI: begin wr = 1'b1; widx = 5'(x.src_a); wval = {x.imm8, 8'h00}; end
			OP_BEQ: if (a == b) npc = x.pc_in + simm4;
			OP_BLT: if ($signed(a) < $signed(b)) npc = x.pc_in + simm4;
			OP_J: npc = a + simm8;
			OP_JAL: begin
				wr = 1'b1;
				widx = LINK_REG;
				wval = x.pc_in;
				npc = a + simm8;
			end
		endcase
		if (wr && widx != 5'd0) begin
			rf_model[widx] = wval;
		end else begin
			wr = 1'b0;
			widx = '0;
			wval = '0;
		end
		rf_model[0] = '0;
		r.next_pc = npc;
		r.reg_written = wr;
		r.written_index = widx;
		r.written_value = wval;
		return r;
	endfunction

	function automatic dir_row_t row(op_t op, int a, int b, int d, int i4, int i8, int pc,
			bit known, int npc = 0, int wr = 0, int widx = 0, int wval = 0);
		dir_row_t r;
		r.instr.op = op;
		r.instr.src_a = 4'(a);
		r.instr.src_b = 4'(b);
		r.instr.dest = 4'(d);
		r.instr.imm4 = 4'(i4);
		r.instr.imm8 = 8'(i8);
		r.instr.pc_in = 16'(pc);
		r.known = known;
		r.want.next_pc = 16'(npc);
		r.want.reg_written = 1'(wr);
		r.want.written_index = 5'(widx);
		r.want.written_value = 16'(wval);
		return r;
	endfunction

	function automatic in_item_t random_instr();
		in_item_t x;
		x.op = 4'($urandom);
		x.src_a = ($urandom_range(0, 1) == 0) ? 4'($urandom_range(0, 3)) : 4'($urandom);
		x.src_b = ($urandom_range(0, 1) == 0) ? 4'($urandom_range(0, 3)) : 4'($urandom);
		x.dest = ($urandom_range(0, 1) == 0) ? 4'($urandom_range(0, 3)) : 4'($urandom);
		x.imm4 = 4'($urandom);
		x.imm8 = 8'($urandom);
		x.pc_in = 16'($urandom);
		if (x.op == OP_SHIFT && $urandom_range(0, 1) == 0)
			x.imm8 = 8'(int'($urandom_range(0, 34)) - 17);
		if ((x.op == OP_BEQ || x.op == OP_BLT) && $urandom_range(0, 2) == 0)
			x.src_b = x.src_a;
		return x;
	endfunction

	task automatic send_instr(in_item_t x, bit known, out_item_t typed);
		int gap;
		out_item_t got;
		gap = 0;
		while ($urandom_range(0, 99) < gap_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= x;
		do @(posedge clk); while (in_ready !== 1'b1);
		got = execute_instr(x);
		pending_results.push_back(known ? typed : got);
	endtask

	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t: %s expected %h got %h", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		out_item_t want;
		out_ready <= ($urandom_range(0, 99) >= stall_pct);
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result item %h", $time, out_data);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if ($isunknown(out_data)) begin
					$display("%0t: result expected %h got %h", $time, want, out_data);
					mismatches++;
				end else begin
					check_field("next_pc", int'(want.next_pc), int'(out_data.next_pc));
					check_field("reg_written", int'(want.reg_written),
						int'(out_data.reg_written));
					check_field("written_index", int'(want.written_index),
						int'(out_data.written_index));
					check_field("written_value", int'(want.written_value),
						int'(out_data.written_value));
				end
			end
		end
	end

	initial begin
		out_item_t none;
		in_item_t  x;
		int        n;
		int        chunk;
		none = '0;
		foreach (rf_model[i])
			rf_model[i] = '0;
		foreach (dmem_model[i])
			dmem_model[i] = '0;

		dir_tab.push_back(row(OP_LUI, 1, 0, 0, 0, 127, 16'h0001, 1, 16'h0001, 1, 1, 16'h7F00));
		dir_tab.push_back(row(OP_ADDI, 1, 0, 0, 0, 127, 16'hFFFF, 1, 16'hFFFF, 1, 1, 16'h7F7F));
		dir_tab.push_back(row(OP_LUI, 2, 0, 0, 0, -128, 0, 1, 0, 1, 2, 16'h8000));
		dir_tab.push_back(row(OP_ADDI, 3, 0, 0, 0, -1, 0, 1, 0, 1, 3, 16'hFFFF));
		dir_tab.push_back(row(OP_ADD, 1, 2, 4, 0, 0, 16'h0100, 0));
		dir_tab.push_back(row(OP_SUB, 2, 3, 5, 0, 0, 16'h0101, 0));
		dir_tab.push_back(row(OP_AND, 1, 3, 6, 0, 0, 16'h0102, 0));
		dir_tab.push_back(row(OP_OR, 2, 1, 7, 0, 0, 16'h0103, 0));
		dir_tab.push_back(row(OP_XOR, 4, 3, 8, 0, 0, 16'h0104, 0));
		dir_tab.push_back(row(OP_NOT, 9, 0, 0, 0, 0, 16'h0105, 1, 16'h0105, 1, 9, 16'hFFFF));
		dir_tab.push_back(row(OP_SLT, 2, 1, 10, 0, 0, 16'h0106, 1, 16'h0106, 1, 10, 1));
		// address wraps: 0x7F7F + 0x8000 lands on word 0xF7F
		dir_tab.push_back(row(OP_SW, 1, 2, 4, 0, 0, 16'h0200, 1, 16'h0200, 0, 0, 0));
		dir_tab.push_back(row(OP_LW, 1, 2, 11, 0, 0, 16'h0201, 0));
		dir_tab.push_back(row(OP_LW, 0, 0, 12, 0, 0, 16'h0202, 1, 16'h0202, 1, 12, 0));
		dir_tab.push_back(row(OP_SHIFT, 3, 0, 0, 0, -128, 16'h0300, 1, 16'h0300, 1, 3, 0));
		dir_tab.push_back(row(OP_SHIFT, 2, 0, 0, 0, 127, 16'h0301, 1, 16'h0301, 1, 2, 16'hFFFF));
		dir_tab.push_back(row(OP_SHIFT, 4, 0, 0, 0, 0, 16'h0302, 0));
		dir_tab.push_back(row(OP_SHIFT, 1, 0, 0, 0, -15, 16'h0303, 0));
		dir_tab.push_back(row(OP_ADD, 1, 2, 0, 0, 0, 16'h0400, 1, 16'h0400, 0, 0, 0));
		dir_tab.push_back(row(OP_LUI, 0, 0, 0, 0, 5, 16'h0401, 1, 16'h0401, 0, 0, 0));
		dir_tab.push_back(row(OP_BEQ, 0, 0, 0, -8, 0, 16'h0003, 1, 16'hFFFB, 0, 0, 0));
		dir_tab.push_back(row(OP_BEQ, 1, 2, 0, 7, 0, 16'h1234, 1, 16'h1234, 0, 0, 0));
		dir_tab.push_back(row(OP_BLT, 2, 0, 0, 7, 0, 16'hFFFC, 1, 16'h0003, 0, 0, 0));
		dir_tab.push_back(row(OP_BLT, 0, 2, 0, -1, 0, 16'h8000, 1, 16'h8000, 0, 0, 0));
		dir_tab.push_back(row(OP_J, 0, 0, 0, 0, -128, 16'h5555, 1, 16'hFF80, 0, 0, 0));
		dir_tab.push_back(row(OP_JAL, 0, 0, 0, 0, 5, 16'hABCD, 1, 16'h0005, 1, 16, 16'hABCD));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_tab[i])
			send_instr(dir_tab[i].instr, dir_tab[i].known, dir_tab[i].want);

		// idle phases: none, sender, receiver, both
		n = 0;
		while (n < 1024) begin
			chunk = n / 128;
			gap_pct = (chunk % 4 == 1) ? 49 : (chunk % 4 == 3) ? 30 : 0;
			stall_pct = (chunk % 4 == 2) ? 49 : (chunk % 4 == 3) ? 30 : 0;
			x = random_instr();
			if ($urandom_range(0, 99) < 20) begin
				// store then load back through the same address registers
				x.op = OP_SW;
				send_instr(x, 1'b0, none);
				x.op = OP_LW;
				x.dest = 4'($urandom);
				send_instr(x, 1'b0, none);
				n += 2;
			end else begin
				send_instr(x, 1'b0, none);
				n++;
			end
		end
		in_valid <= 1'b0;
		while (pending_results.size() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

### filelist.f
rtl/core/rx16_pkg.sv
rtl/core/rx16_regfile.sv
rtl/core/rx16_dmem.sv
rtl/core/rx16_alu.sv
rtl/core/risc16_execute_stage.sv
test/testbench.sv
